// ----- rtl/nmc_pkg.sv -----
// ----------------------------------------------------------------------------
// nmc_pkg
// Shared types and codes for the neighbourhood mask combiner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nmc_pkg;

	// request item codes
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] MASK_SET   = 8'hFF;
	localparam logic [7:0] MASK_CLEAR = 8'h00;

	localparam logic [15:0] MIN_HEIGHT   = 16'd3;
	localparam logic [15:0] RESET_HEIGHT = 16'd1080;
	localparam int          RESET_WIDTH  = 2048;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic       func;
		logic [7:0] strong_value;
		logic [7:0] weak_value;
	} nmc_item_t;

	typedef struct packed {
		logic [7:0] mask_out;
		logic       row_end;
		logic       frame_end;
	} nmc_result_t;

	// one line memory entry
	typedef struct packed {
		logic [7:0] weak_mask;
		logic [7:0] centre;
		logic [7:0] above;
	} nmc_line_t;

	// classified request handed from front to back
	typedef struct packed {
		logic       flush;
		logic       emit;
		logic       last;
		logic       at_edge;
		logic [7:0] strong_mask;
		logic [7:0] a_above;
		logic [7:0] a_centre;
		logic [7:0] a_weak;
		logic [7:0] b_above;
		logic [7:0] b_centre;
	} nmc_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/nmc_ram.sv -----
// ----------------------------------------------------------------------------
// nmc_ram
// Generic memory, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output      logic [WIDTH-1:0] rd_data_a,
	output      logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/nmc_front.sv -----
// ----------------------------------------------------------------------------
// nmc_front
// Accepts requests, tracks row and column, drives the line memory and
// hands classified requests to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmc_front #(
	parameter int MAX_WIDTH = 2048,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output      logic               item_ready,
	input  wire nmc_pkg::nmc_item_t item,
	input  wire logic [CW-1:0]      last_col,
	input  wire logic [15:0]        height,
	output      logic               rd_en,
	output      logic [CW-1:0]      rd_addr_a,
	output      logic [CW-1:0]      rd_addr_b,
	input  wire nmc_pkg::nmc_line_t rd_data_a,
	input  wire nmc_pkg::nmc_line_t rd_data_b,
	output      logic               wr_en,
	output      logic [CW-1:0]      wr_addr,
	output      nmc_pkg::nmc_line_t wr_data,
	output      logic               push_valid,
	input  wire logic               push_ready,
	output      nmc_pkg::nmc_cmd_t  push_cmd
);

	import nmc_pkg::*;

	logic [CW-1:0] col_q;
	logic [15:0]   row_q;

	logic          valid_s1;
	logic          flush_s1;
	logic          emit_s1;
	logic          last_s1;
	logic          at_edge_s1;
	logic          row_one_s1;
	logic [CW-1:0] col_s1;
	logic [7:0]    strong_s1;
	logic [7:0]    weak_s1;

	logic is_flush;
	logic frame_full;
	logic last_hit;
	logic take;

	assign is_flush   = (item.func == FUNC_FLUSH);
	assign frame_full = (row_q >= height);
	assign last_hit   = (col_q >= last_col);
	assign item_ready = !valid_s1 || push_ready;
	assign take       = item_valid && item_ready && (is_flush == frame_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last_hit) begin
				col_q <= '0;
				row_q <= is_flush ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flush_s1   <= is_flush;
			emit_s1    <= (row_q != 16'd0) && (col_q != '0);
			last_s1    <= last_hit;
			at_edge_s1 <= is_flush ? (col_q == '0) : (col_q == CW'(1));
			row_one_s1 <= (row_q == 16'd1);
			col_s1     <= col_q;
			strong_s1  <= item.strong_value;
			weak_s1    <= item.weak_value;
		end
	end

	// line memory reads at acceptance, write-back as the request leaves
	assign rd_en     = take;
	assign rd_addr_a = col_q;
	assign rd_addr_b = last_hit ? last_col - CW'(1) : col_q + CW'(1);

	assign wr_en             = valid_s1 && push_ready && !flush_s1;
	assign wr_addr           = col_s1;
	assign wr_data.weak_mask = weak_s1;
	assign wr_data.centre    = strong_s1;
	assign wr_data.above     = rd_data_a.centre;

	assign push_valid = valid_s1;

	always_comb begin
		push_cmd             = '0;
		push_cmd.flush       = flush_s1;
		push_cmd.emit        = emit_s1;
		push_cmd.last        = last_s1;
		push_cmd.at_edge     = at_edge_s1;
		push_cmd.strong_mask = strong_s1;
		push_cmd.a_above     = row_one_s1 ? strong_s1 : rd_data_a.above;
		push_cmd.a_centre    = rd_data_a.centre;
		push_cmd.a_weak      = rd_data_a.weak_mask;
		push_cmd.b_above     = rd_data_b.above;
		push_cmd.b_centre    = rd_data_b.centre;
	end

endmodule

`default_nettype wire

// ----- rtl/nmc_queue.sv -----
// ----------------------------------------------------------------------------
// nmc_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output      logic              push_ready,
	input  wire nmc_pkg::nmc_cmd_t push_cmd,
	output      logic              pop_valid,
	input  wire logic              pop_ready,
	output      nmc_pkg::nmc_cmd_t pop_cmd
);

	import nmc_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	nmc_cmd_t       slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;

	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/nmc_back.sv -----
// ----------------------------------------------------------------------------
// nmc_back
// Keeps the 3x3 window column sums, makes the mask decisions and drives
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           threshold,
	input  wire logic                 pop_valid,
	output      logic                 pop_ready,
	input  wire nmc_pkg::nmc_cmd_t    pop_cmd,
	output      logic                 result_valid,
	input  wire logic                 result_ready,
	output      nmc_pkg::nmc_result_t result
);

	import nmc_pkg::*;

	function automatic logic decide(
		input logic [9:0] sl,
		input logic [9:0] sm,
		input logic [9:0] sr,
		input logic       strong_set,
		input logic [7:0] weak_byte,
		input logic [7:0] thr
	);
		logic [11:0] total;
		logic [7:0]  sat;
		total = 12'(sl) + 12'(sm) + 12'(sr);
		sat   = (total > 12'd255) ? 8'hFF : total[7:0];
		return strong_set || ((weak_byte != 8'd0) && (sat >= thr));
	endfunction

	logic [9:0]  sum_prev_q;
	logic [9:0]  sum_cur_q;
	logic        strong_cur_q;
	logic [7:0]  weak_hold_q;

	logic        out_valid_q;
	nmc_result_t out_q;
	logic        pend_valid_q;
	nmc_result_t pend_q;

	logic        out_free;
	logic        do_pop;
	logic [1:0]  cmd_results;
	logic [7:0]  below;
	logic [9:0]  col_a_sum;
	logic [9:0]  col_b_sum;
	logic [9:0]  dec_a_left;
	logic [9:0]  dec_b_left;
	logic [9:0]  dec_b_right;
	logic        pass_a;
	logic        pass_b;
	nmc_result_t first_res;
	nmc_result_t second_res;

	// a waiting second result still lets requests with one result or none through
	assign cmd_results = pop_cmd.flush ? 2'd1 : !pop_cmd.emit ? 2'd0 :
		pop_cmd.last ? 2'd2 : 2'd1;
	assign out_free  = !out_valid_q || result_ready;
	assign pop_ready = out_free && (!pend_valid_q || (cmd_results != 2'd2));
	assign do_pop    = pop_valid && pop_ready;

	// flush columns mirror the row above below the centre
	assign below     = pop_cmd.flush ? pop_cmd.a_above : pop_cmd.strong_mask;
	assign col_a_sum = 10'(pop_cmd.a_above) + 10'(pop_cmd.a_centre) + 10'(below);
	assign col_b_sum = 10'({pop_cmd.b_above, 1'b0}) + 10'(pop_cmd.b_centre);

	// pixel result for the column before last
	assign dec_a_left = pop_cmd.at_edge ? col_a_sum : sum_prev_q;
	assign pass_a     = decide(dec_a_left, sum_cur_q, col_a_sum, strong_cur_q,
		weak_hold_q, threshold);

	// row end result or flush result, both centred on the read column
	assign dec_b_left  = (pop_cmd.flush && pop_cmd.at_edge) ? col_b_sum : sum_cur_q;
	assign dec_b_right = pop_cmd.flush ? col_b_sum : sum_cur_q;
	assign pass_b      = decide(dec_b_left, col_a_sum, dec_b_right,
		pop_cmd.a_centre != 8'd0, pop_cmd.a_weak, threshold);

	always_comb begin
		first_res.mask_out  = (pop_cmd.flush ? pass_b : pass_a) ? MASK_SET : MASK_CLEAR;
		first_res.row_end   = pop_cmd.flush && pop_cmd.last;
		first_res.frame_end = pop_cmd.flush && pop_cmd.last;
		second_res.mask_out  = pass_b ? MASK_SET : MASK_CLEAR;
		second_res.row_end   = 1'b1;
		second_res.frame_end = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_prev_q   <= '0;
			sum_cur_q    <= '0;
			strong_cur_q <= 1'b0;
			weak_hold_q  <= '0;
		end else if (do_pop) begin
			if (!pop_cmd.flush) begin
				sum_prev_q   <= sum_cur_q;
				sum_cur_q    <= col_a_sum;
				strong_cur_q <= (pop_cmd.a_centre != 8'd0);
				weak_hold_q  <= pop_cmd.a_weak;
			end else if (pop_cmd.last) begin
				sum_prev_q   <= '0;
				sum_cur_q    <= '0;
				strong_cur_q <= 1'b0;
				weak_hold_q  <= '0;
			end else begin
				sum_cur_q <= col_a_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= do_pop && (cmd_results != 2'd0);
			end else if (do_pop) begin
				out_valid_q  <= (cmd_results != 2'd0);
				pend_valid_q <= (cmd_results == 2'd2);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
				if (do_pop) begin
					pend_q <= first_res;
				end
			end else if (do_pop) begin
				out_q  <= first_res;
				pend_q <= second_res;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ----- rtl/neighbourhood_mask_combine.sv -----
// ----------------------------------------------------------------------------
// neighbourhood_mask_combine
// Merges a strong and a weak motion mask with a 3x3 strong-sum test.
//
// Requests enter on item (valid/ready) in raster order, one pixel each with
// func set to pixel; results leave on result (valid/ready). A pixel output is
// 255 if its strong byte is set, or if its weak byte is set and the
// saturated 3x3 strong sum reaches threshold. Frame edges mirror.
// Output lags one row and one pixel: pixel (r, c) is released by the
// request for (r+1, c+1), the row's last request releases two results.
// After the frame, one flush request per pixel releases the final row.
// A result passes the front register, the queue and the result register.
// Throughput is one request per cycle while the receiver keeps up, set by
// the line memory and the registered window update. A four-entry queue
// between request side and result side absorbs a stalled receiver;
// item_ready drops only when it is full. Reset clears counters and sets
// threshold 0, width 2048, height 1080; the line memory is not cleared
// and is fully rewritten by each frame. Configuration (cfg_en, cfg_index,
// cfg_data) must be written while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module neighbourhood_mask_combine #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_en,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [nmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                item_valid,
	output      logic                                item_ready,
	input  wire nmc_pkg::nmc_item_t                  item,
	output      logic                                result_valid,
	input  wire logic                                result_ready,
	output      nmc_pkg::nmc_result_t                result
);

	import nmc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > 12) ? CW + 1 : 12;
	localparam int LW = $bits(nmc_line_t);
	localparam int RESET_LAST = ((MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

	logic [7:0]    threshold_q;
	logic [CW-1:0] last_col_q;
	logic [15:0]   height_q;

	logic [EW-1:0] width_req;
	logic [CW-1:0] last_col_req;

	assign width_req = EW'(cfg_data[11:0]);

	always_comb begin
		if (width_req < EW'(3)) begin
			last_col_req = CW'(2);
		end else if (width_req > EW'(MAX_WIDTH)) begin
			last_col_req = CW'(MAX_WIDTH - 1);
		end else begin
			last_col_req = CW'(width_req - EW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			last_col_q  <= CW'(RESET_LAST);
			height_q    <= RESET_HEIGHT;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_THRESHOLD: begin
					threshold_q <= cfg_data[7:0];
				end
				REG_FRAME_WIDTH: begin
					last_col_q <= last_col_req;
				end
				REG_FRAME_HEIGHT: begin
					height_q <= (cfg_data < MIN_HEIGHT) ? MIN_HEIGHT : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	logic          rd_en;
	logic [CW-1:0] rd_addr_a;
	logic [CW-1:0] rd_addr_b;
	nmc_line_t     rd_data_a;
	nmc_line_t     rd_data_b;
	logic          wr_en;
	logic [CW-1:0] wr_addr;
	nmc_line_t     wr_data;

	logic     push_valid;
	logic     push_ready;
	nmc_cmd_t push_cmd;
	logic     pop_valid;
	logic     pop_ready;
	nmc_cmd_t pop_cmd;

	nmc_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	nmc_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.last_col   (last_col_q),
		.height     (height_q),
		.rd_en      (rd_en),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.rd_data_a  (rd_data_a),
		.rd_data_b  (rd_data_b),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	nmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	nmc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.threshold    (threshold_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
